// ===== rtl/rbb_pkg.sv =====
package rbb_pkg;

	// default geometry of the block
	localparam int COORD_WIDTH_DEF    = 24;
	localparam int ANGLE_WIDTH_DEF    = 16;
	localparam int TRIG_FRAC_BITS_DEF = 15;

	// fixed width of the yaw field
	localparam int YAW_WIDTH = 16;

	// sine polynomial constants in q30
	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic [30:0] POLY_A  = 31'd1686629713;
	localparam logic [29:0] POLY_B  = 30'd688904866;
	localparam logic [26:0] POLY_C  = 27'd76016977;

	// quarter turn in a 32-bit phase
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

endpackage

// ===== rtl/rbb_in_if.sv =====
interface rbb_in_if
	import rbb_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic        [YAW_WIDTH-1:0]   yaw_angle;
	logic signed [COORD_WIDTH-1:0] box_min_x;
	logic signed [COORD_WIDTH-1:0] box_min_y;
	logic signed [COORD_WIDTH-1:0] box_min_z;
	logic signed [COORD_WIDTH-1:0] box_max_x;
	logic signed [COORD_WIDTH-1:0] box_max_y;
	logic signed [COORD_WIDTH-1:0] box_max_z;

	modport source (
		output valid, yaw_angle, box_min_x, box_min_y, box_min_z,
		       box_max_x, box_max_y, box_max_z,
		input  ready
	);
	modport sink (
		input  valid, yaw_angle, box_min_x, box_min_y, box_min_z,
		       box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

// ===== rtl/rbb_out_if.sv =====
interface rbb_out_if
	import rbb_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] bound_min_x;
	logic signed [COORD_WIDTH-1:0] bound_min_y;
	logic signed [COORD_WIDTH-1:0] bound_min_z;
	logic signed [COORD_WIDTH-1:0] bound_max_x;
	logic signed [COORD_WIDTH-1:0] bound_max_y;
	logic signed [COORD_WIDTH-1:0] bound_max_z;

	modport source (
		output valid, bound_min_x, bound_min_y, bound_min_z,
		       bound_max_x, bound_max_y, bound_max_z,
		input  ready
	);
	modport sink (
		input  valid, bound_min_x, bound_min_y, bound_min_z,
		       bound_max_x, bound_max_y, bound_max_z,
		output ready
	);
endinterface

// ===== rtl/rbb_sine.sv =====
module rbb_sine
	import rbb_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [31:0]                 phase,
	output logic signed [TRIG_FRAC_BITS:0] value
);
	localparam int F = TRIG_FRAC_BITS;

	logic [30:0] x_s1, x_s2, x_s3;
	logic [1:0]  quad_s1, quad_s2, quad_s3;
	logic [30:0] x2_s1, x2_s2;
	logic [29:0] t_s2;
	logic [30:0] u_s3;

	logic [30:0] x_in;
	logic [61:0] sq_prod;
	logic [57:0] c_prod;
	logic [60:0] t_prod;
	logic [61:0] u_prod;
	logic [31:0] s30;
	logic [32:0] rnd;
	logic [32:0] lim;
	logic [F:0]  mag;

	// fold the phase into the first quarter
	always_comb begin
		x_in = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
	end

	// stage 1: square of the fraction
	assign sq_prod = 62'(x_in) * 62'(x_in);
	// stage 2: first polynomial term
	assign c_prod = 58'(x2_s1) * 58'(POLY_C);
	// stage 3: second polynomial term
	assign t_prod = 61'(x2_s2) * 61'(t_s2);
	// stage 4: final product, round and saturate
	assign u_prod = 62'(x_s3) * 62'(u_s3);
	assign s30 = u_prod[61:30];
	assign rnd = ({1'b0, s30} + (33'd1 << (29 - F))) >> (30 - F);
	assign lim = (33'd1 << F) - 33'd1;
	assign mag = (rnd > lim) ? lim[F:0] : rnd[F:0];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_in;
			quad_s1 <= phase[31:30];
			x2_s1   <= sq_prod[60:30];

			x_s2    <= x_s1;
			quad_s2 <= quad_s1;
			x2_s2   <= x2_s1;
			t_s2    <= POLY_B - c_prod[57:30];

			x_s3    <= x_s2;
			quad_s3 <= quad_s2;
			u_s3    <= POLY_A - t_prod[60:30];

			value   <= quad_s3[1] ? -$signed(mag) : $signed(mag);
		end
	end
endmodule

// ===== rtl/rbb_rotate.sv =====
module rbb_rotate
	import rbb_pkg::*;
#(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [TRIG_FRAC_BITS:0] sin_v,
	input  logic signed [TRIG_FRAC_BITS:0] cos_v,
	input  logic signed [COORD_WIDTH-1:0] xs [2],
	input  logic signed [COORD_WIDTH-1:0] ys [2],
	output logic signed [COORD_WIDTH-1:0] rx [4],
	output logic signed [COORD_WIDTH-1:0] ry [4]
);
	localparam int W  = COORD_WIDTH;
	localparam int F  = TRIG_FRAC_BITS;
	localparam int PW = W + F + 1;
	localparam int SW = W + F + 2;

	logic signed [PW-1:0] cx_s5 [2];
	logic signed [PW-1:0] sx_s5 [2];
	logic signed [PW-1:0] cy_s5 [2];
	logic signed [PW-1:0] sy_s5 [2];

	function automatic logic signed [W-1:0] round_sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] b;
		logic signed [SW-1:0] sh;
		logic signed [W+1:0]  r;
		logic signed [W+1:0]  hi;
		logic signed [W+1:0]  lo;
		b  = v + (SW'(1) <<< (F - 1));
		sh = b >>> F;
		r  = sh[W+1:0];
		hi = (W+2)'((1 <<< (W - 1)) - 1);
		lo = -((W+2)'(1) <<< (W - 1));
		if (r > hi) return hi[W-1:0];
		if (r < lo) return lo[W-1:0];
		return r[W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 5: products of trig values and corners
			for (int i = 0; i < 2; i++) begin
				cx_s5[i] <= PW'(cos_v) * PW'(xs[i]);
				sx_s5[i] <= PW'(sin_v) * PW'(xs[i]);
				cy_s5[i] <= PW'(cos_v) * PW'(ys[i]);
				sy_s5[i] <= PW'(sin_v) * PW'(ys[i]);
			end
			// stage 6: corner sums, rounded onto the grid and clamped
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					rx[2*i+j] <= round_sat(SW'(cx_s5[i]) - SW'(sy_s5[j]));
					ry[2*i+j] <= round_sat(SW'(sx_s5[i]) + SW'(cy_s5[j]));
				end
			end
		end
	end
endmodule

// ===== rtl/rotated_box_bounds.sv =====
// Axis-aligned bounds of a box after a rotation about z by a yaw angle.
// in_ch carries one box beat: a yaw binary angle and the min and max
// corners in Q16.8. out_ch carries one beat of bounds per input beat, in
// order: x and y are the min and max over the four rotated corners,
// clamped to the coordinate range; z is the smaller and larger input z.
// From accept to a valid result a beat passes four stages of
// the sine polynomial (square, two Horner terms, final product with
// rounding), one of corner products, one of rounded sums and one of the
// min/max reduction that also serves as the output register.
// Throughput is one beat per cycle unless out_ch stalls; one pipeline
// enable moves every stage. When out_ch stalls with a result waiting,
// the whole pipeline holds and in_ch.ready drops in the same cycle;
// bubbles inside the pipe are not squeezed out during the hold, and no
// beat is lost or repeated. Reset clears the stage valid bits only;
// after reset the block is empty and ready at once.
module rotated_box_bounds
	import rbb_pkg::*;
#(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rbb_in_if.sink     in_ch,
	rbb_out_if.source  out_ch
);
	localparam int W = COORD_WIDTH;
	localparam int F = TRIG_FRAC_BITS;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [31:0] yaw_ext;
	logic [31:0] phase_sin;
	logic [31:0] phase_cos;
	logic signed [F:0] sin_v, cos_v;

	logic signed [W-1:0] xs_s1 [2], xs_s2 [2], xs_s3 [2], xs_s4 [2];
	logic signed [W-1:0] ys_s1 [2], ys_s2 [2], ys_s3 [2], ys_s4 [2];
	logic signed [W-1:0] zs_s1 [2], zs_s2 [2], zs_s3 [2], zs_s4 [2];
	logic signed [W-1:0] zs_s5 [2], zs_s6 [2];
	logic signed [W-1:0] rx [4];
	logic signed [W-1:0] ry [4];
	logic signed [W-1:0] mnx, mxx, mny, mxy;

	// one enable for the whole pipe
	assign en          = !v_s7 || out_ch.ready;
	assign in_ch.ready = en;

	// angle to 32-bit phase, extra angle bits drop off the top
	assign yaw_ext   = 32'(in_ch.yaw_angle);
	assign phase_sin = yaw_ext << (32 - ANGLE_WIDTH);
	assign phase_cos = phase_sin + QUARTER_TURN;

	rbb_sine #(.TRIG_FRAC_BITS(F)) u_sin (
		.clk(clk), .en(en), .phase(phase_sin), .value(sin_v)
	);
	rbb_sine #(.TRIG_FRAC_BITS(F)) u_cos (
		.clk(clk), .en(en), .phase(phase_cos), .value(cos_v)
	);

	rbb_rotate #(.COORD_WIDTH(W), .TRIG_FRAC_BITS(F)) u_rot (
		.clk(clk), .en(en), .sin_v(sin_v), .cos_v(cos_v),
		.xs(xs_s4), .ys(ys_s4), .rx(rx), .ry(ry)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	// corner delay line alongside the sine stages
	always_ff @(posedge clk) begin
		if (en) begin
			xs_s1[0] <= in_ch.box_min_x; xs_s1[1] <= in_ch.box_max_x;
			ys_s1[0] <= in_ch.box_min_y; ys_s1[1] <= in_ch.box_max_y;
			zs_s1[0] <= in_ch.box_min_z; zs_s1[1] <= in_ch.box_max_z;
			xs_s2 <= xs_s1; xs_s3 <= xs_s2; xs_s4 <= xs_s3;
			ys_s2 <= ys_s1; ys_s3 <= ys_s2; ys_s4 <= ys_s3;
			zs_s2 <= zs_s1; zs_s3 <= zs_s2; zs_s4 <= zs_s3;
			zs_s5 <= zs_s4; zs_s6 <= zs_s5;
		end
	end

	// min and max over the four corners
	always_comb begin
		mnx = rx[0]; mxx = rx[0]; mny = ry[0]; mxy = ry[0];
		for (int k = 1; k < 4; k++) begin
			if (rx[k] < mnx) mnx = rx[k];
			if (rx[k] > mxx) mxx = rx[k];
			if (ry[k] < mny) mny = ry[k];
			if (ry[k] > mxy) mxy = ry[k];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.bound_min_x <= mnx;
			out_ch.bound_max_x <= mxx;
			out_ch.bound_min_y <= mny;
			out_ch.bound_max_y <= mxy;
			out_ch.bound_min_z <= (zs_s6[0] < zs_s6[1]) ? zs_s6[0] : zs_s6[1];
			out_ch.bound_max_z <= (zs_s6[0] > zs_s6[1]) ? zs_s6[0] : zs_s6[1];
		end
	end

	assign out_ch.valid = v_s7;
endmodule
